// ----- sv/fcmap4_pkg.sv -----
// Shared types and codes for the format-4 character map lookup block.
// No dependencies; imported by font_cmap_format4_lookup.
package fcmap4_pkg;

  // request opcodes
  localparam logic [1:0] OP_WR_SEG   = 2'd0;
  localparam logic [1:0] OP_WR_GLYPH = 2'd1;
  localparam logic [1:0] OP_LOOKUP   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_FOUND      = 2'd0;
  localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
  localparam logic [1:0] ST_OUT_RANGE  = 2'd2;

  // configuration register indexes
  localparam logic CFG_SEG_COUNT   = 1'b0;
  localparam logic CFG_GLYPH_COUNT = 1'b1;

  localparam logic [15:0] NOT_FOUND_GLYPH = 16'hFFFF;

  // ro/2 + segment number + (code - start) stays below 2^17
  localparam int unsigned SUM_W = 17;
  localparam int unsigned IDX_W = SUM_W + 1;

  typedef struct packed {
    logic [15:0] end_code;
    logic [15:0] start_code;
    logic [15:0] delta;
    logic [15:0] range_offset;
  } seg_entry_t;

endpackage

// ----- sv/font_cmap_format4_lookup.sv -----
// Format-4 character map lookup: segment table, glyph array and scan sequencer.
// Depends on fcmap4_pkg.
//
// Segment and glyph-array write requests give no result. A lookup request
// walks the segment memory through its single read port, one segment per
// cycle, and stops at the first segment whose end code is at or above the
// character code. It then reads the glyph array, reports an out-of-range
// array index, or gives its result without reading the array when the code
// is not mapped or the delta is used directly. The segment count n is capped
// at SEG_MAX, and a code that no segment covers ends the scan after segment
// n - 1 as not mapped. The block takes no new request while a lookup is in
// flight; the result sits in an output register until it is taken.
module font_cmap_format4_lookup
  import fcmap4_pkg::*;
#(
  parameter int unsigned SEG_MAX   = 64,
  parameter int unsigned GLYPH_MAX = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  in_op_i,
  input  logic [9:0]  in_slot_i,
  input  logic [15:0] in_seg_end_i,
  input  logic [15:0] in_seg_start_i,
  input  logic [15:0] in_seg_delta_i,
  input  logic [15:0] in_seg_range_offset_i,
  input  logic [15:0] in_array_word_i,
  input  logic [15:0] in_char_code_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_glyph_o,
  output logic [1:0]  out_status_o
);

  localparam int unsigned SA   = (SEG_MAX > 1) ? $clog2(SEG_MAX) : 1;
  localparam int unsigned GA   = (GLYPH_MAX > 1) ? $clog2(GLYPH_MAX) : 1;
  localparam int unsigned SCW  = $clog2(SEG_MAX + 1);
  localparam int unsigned GCW  = $clog2(GLYPH_MAX + 1);
  localparam int unsigned NSW  = (SCW > 7) ? SCW : 7;
  localparam int unsigned NWW  = (GCW > 11) ? GCW : 11;
  localparam logic [10:0] SEG_LIM   = 11'(SEG_MAX);
  localparam logic [16:0] GLYPH_LIM = 17'(GLYPH_MAX);
  localparam logic [NSW-1:0] SEG_CAP   = NSW'(SEG_MAX);
  localparam logic [NWW-1:0] GLYPH_CAP = NWW'(GLYPH_MAX);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_HIT    = 3'd2;
  localparam logic [2:0] S_IDX    = 3'd3;
  localparam logic [2:0] S_CHK    = 3'd4;
  localparam logic [2:0] S_GWAIT  = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  // configuration
  logic [6:0]  seg_count_q;
  logic [10:0] glyph_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q   <= '0;
      glyph_count_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SEG_COUNT) begin
        seg_count_q <= cfg_wdata_i[6:0];
      end else begin
        glyph_count_q <= cfg_wdata_i;
      end
    end
  end

  logic [NSW-1:0] seg_count_ext;
  logic [NWW-1:0] glyph_count_ext;
  assign seg_count_ext   = NSW'(seg_count_q);
  assign glyph_count_ext = NWW'(glyph_count_q);

  // sequencer state
  logic [2:0]       state_q, state_d;
  logic [15:0]      code_q;
  logic [NSW-1:0]   nseg_q;
  logic [NWW-1:0]   nword_q;
  logic [NSW-1:0]   rd_idx_q;
  logic [SA-1:0]    cur_q;
  logic             rdv_q;
  logic [SUM_W-1:0] sum_q;
  logic [IDX_W-1:0] diff_q;
  logic [15:0]      res_glyph_q;
  logic [1:0]       res_status_q;
  logic             out_valid_q;
  logic [15:0]      out_glyph_q;
  logic [1:0]       out_status_q;

  // memories
  seg_entry_t  seg_mem [SEG_MAX];
  logic [15:0] glyph_mem [GLYPH_MAX];
  seg_entry_t  seg_rd_q;
  logic [15:0] glyph_rd_q;

  logic in_acc;
  logic seg_we, glyph_we;
  logic seg_re, glyph_re;
  logic seg_hit;
  logic seg_last;
  seg_entry_t wr_entry;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign seg_we     = in_acc && (in_op_i == OP_WR_SEG) && ({1'b0, in_slot_i} < SEG_LIM);
  assign glyph_we   = in_acc && (in_op_i == OP_WR_GLYPH) &&
                      ({7'd0, in_slot_i} < GLYPH_LIM);

  assign wr_entry = '{end_code:     in_seg_end_i,
                      start_code:   in_seg_start_i,
                      delta:        in_seg_delta_i,
                      range_offset: in_seg_range_offset_i};

  assign seg_hit  = rdv_q && (seg_rd_q.end_code >= code_q);
  assign seg_last = (NSW'(cur_q) == nseg_q - NSW'(1));
  // keep the read data still once the matching segment is out
  assign seg_re   = (state_q == S_SCAN) && (rd_idx_q < nseg_q) && !seg_hit;
  assign glyph_re = (state_q == S_CHK) && !diff_q[IDX_W-1] &&
                    (diff_q[SUM_W-1:0] < SUM_W'(nword_q));

  always_ff @(posedge clk_i) begin
    if (seg_we) begin
      seg_mem[in_slot_i[SA-1:0]] <= wr_entry;
    end
    if (seg_re) begin
      seg_rd_q <= seg_mem[rd_idx_q[SA-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (glyph_we) begin
      glyph_mem[GA'(in_slot_i)] <= in_array_word_i;
    end
    if (glyph_re) begin
      glyph_rd_q <= glyph_mem[diff_q[GA-1:0]];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_op_i == OP_LOOKUP)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (nseg_q == '0) begin
          state_d = S_RESULT;
        end else if (seg_hit) begin
          state_d = S_HIT;
        end else if (rdv_q && seg_last) begin
          state_d = S_RESULT;
        end
      end
      S_HIT: begin
        if ((seg_rd_q.start_code > code_q) || (seg_rd_q.range_offset == '0)) begin
          state_d = S_RESULT;
        end else begin
          state_d = S_IDX;
        end
      end
      S_IDX:   state_d = S_CHK;
      S_CHK:   state_d = glyph_re ? S_GWAIT : S_RESULT;
      S_GWAIT: state_d = S_RESULT;
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rdv_q   <= seg_re;
      if ((state_q == S_RESULT) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_op_i == OP_LOOKUP)) begin
      code_q   <= in_char_code_i;
      nseg_q   <= (seg_count_ext > SEG_CAP) ? SEG_CAP : seg_count_ext;
      nword_q  <= (glyph_count_ext > GLYPH_CAP) ? GLYPH_CAP : glyph_count_ext;
      rd_idx_q <= '0;
    end else if (seg_re) begin
      rd_idx_q <= rd_idx_q + NSW'(1);
    end
    if (seg_re) begin
      cur_q <= rd_idx_q[SA-1:0];
    end

    case (state_q)
      S_SCAN: begin
        res_glyph_q  <= NOT_FOUND_GLYPH;
        res_status_q <= ST_NOT_MAPPED;
      end
      S_HIT: begin
        if (seg_rd_q.start_code > code_q) begin
          res_glyph_q  <= NOT_FOUND_GLYPH;
          res_status_q <= ST_NOT_MAPPED;
        end else begin
          res_glyph_q  <= code_q + seg_rd_q.delta;
          res_status_q <= ST_FOUND;
        end
        sum_q <= SUM_W'(seg_rd_q.range_offset[15:1]) + SUM_W'(cur_q) +
                 SUM_W'(code_q - seg_rd_q.start_code);
      end
      S_IDX: begin
        diff_q <= {1'b0, sum_q} - IDX_W'(nseg_q);
      end
      S_CHK: begin
        res_glyph_q  <= NOT_FOUND_GLYPH;
        res_status_q <= ST_OUT_RANGE;
      end
      S_GWAIT: begin
        // a zero array word means missing glyph and takes no delta
        res_glyph_q  <= (glyph_rd_q == '0) ? 16'd0 : glyph_rd_q + seg_rd_q.delta;
        res_status_q <= ST_FOUND;
      end
      default: ;
    endcase

    if ((state_q == S_RESULT) && (!out_valid_q || out_ready_i)) begin
      out_glyph_q  <= res_glyph_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_glyph_o  = out_glyph_q;
  assign out_status_o = out_status_q;

  // a failed lookup always carries the not-found glyph
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != ST_FOUND) |-> out_glyph_o == NOT_FOUND_GLYPH)
    else $error("failed lookup without not-found glyph");

  // a lookup request blocks the input for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_op_i == OP_LOOKUP) |=> !in_ready_o)
    else $error("input ready right after lookup request");

  // segment reads never run past the segments in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdv_q |-> NSW'(cur_q) < nseg_q)
    else $error("segment read beyond segment count");

  // the glyph array is read only inside the loaded words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    glyph_re |-> diff_q[SUM_W-1:0] < SUM_W'(nword_q))
    else $error("glyph array read out of range");

  // a result is only loaded from the result state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_RESULT)
    else $error("result raised outside result state");

endmodule
